// ===== hdl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, field layout and sequencing codes of the sample statistics
// and correlation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int X_W         = 24;
    localparam int COUNT_OUT_W = 11;
    localparam int SUM_OUT_W   = 34;
    localparam int VAR_W       = 47;
    localparam int STD_W       = 24;
    localparam int CORR_W      = 32;
    localparam int CORR_FRAC   = 30;
    localparam int ROOT_IN_W   = 2 * CORR_FRAC + 1;
    localparam int ROOT_W      = CORR_FRAC + 1;

    localparam int S_DATA_W = 2 * X_W;
    localparam int M_DATA_W = 224;
    localparam int M_USER_W = 2;

    localparam int OFF_COUNT = 0;
    localparam int OFF_SUM   = OFF_COUNT + COUNT_OUT_W;
    localparam int OFF_MEAN  = OFF_SUM + SUM_OUT_W;
    localparam int OFF_MIN   = OFF_MEAN + X_W;
    localparam int OFF_MAX   = OFF_MIN + X_W;
    localparam int OFF_VAR   = OFF_MAX + X_W;
    localparam int OFF_STD   = OFF_VAR + VAR_W;
    localparam int OFF_CORR  = OFF_STD + STD_W;

    localparam int USER_STATUS     = 0;
    localparam int USER_CORR_VALID = 1;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_FLUSH,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } ssc_state_t;

    typedef enum logic [3:0] {
        OP_N_SXX,
        OP_SX_SX,
        OP_N_SYY,
        OP_SY_SY,
        OP_N_SXY,
        OP_SX_SY,
        OP_N_N,
        OP_DX_DY,
        OP_A_A,
        OP_DIV_MEAN,
        OP_DIV_VAR,
        OP_DIV_CORR,
        OP_SQRT_VAR,
        OP_SQRT_CORR
    } ssc_op_t;

    localparam ssc_op_t OP_FIRST = OP_N_SXX;
    localparam ssc_op_t OP_LAST  = OP_SQRT_CORR;

    typedef enum logic [1:0] {
        UNIT_MUL,
        UNIT_DIV,
        UNIT_SQRT
    } ssc_unit_t;

    typedef struct packed {
        logic    in_ready;
        logic    clear;
        logic    start_mul;
        logic    start_div;
        logic    start_sqrt;
        logic    latch;
        logic    load_out;
        ssc_op_t op;
    } ssc_cmd_t;

    typedef struct packed {
        logic overflowed;
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic out_busy;
    } ssc_sts_t;

    function automatic ssc_unit_t op_unit(ssc_op_t op);
        ssc_unit_t u;
        if (op inside {OP_DIV_MEAN, OP_DIV_VAR, OP_DIV_CORR}) begin
            u = UNIT_DIV;
        end else if (op inside {OP_SQRT_VAR, OP_SQRT_CORR}) begin
            u = UNIT_SQRT;
        end else begin
            u = UNIT_MUL;
        end
        return u;
    endfunction

endpackage

// ===== hdl/ssc_mul.sv =====
// ----------------------------------------------------------------------------
// ssc_mul
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_mul #(
    parameter int W = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] prod
);

    localparam int CNT_W = $clog2(W + 1);

    logic [2*W-1:0]  mcand_reg;
    logic [W-1:0]    mplier_reg;
    logic [2*W-1:0]  prod_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= (2*W)'(a);
            mplier_reg <= b;
            prod_reg   <= '0;
            cnt_reg    <= CNT_W'(W);
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[2*W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[W-1:1]};
            cnt_reg    <= cnt_reg - CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== hdl/ssc_div.sv =====
// ----------------------------------------------------------------------------
// ssc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_div #(
    parameter int NW  = 8,
    parameter int DVW = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [NW-1:0]  num,
    input  logic [DVW-1:0] den,
    output logic           done,
    output logic [NW-1:0]  quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [DVW-1:0]   rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DVW-1:0]   den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVW:0]     trial;
    logic [DVW:0]     diff;
    logic             ge;

    always_comb begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
            cnt_reg <= CNT_W'(NW);
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/ssc_sqrt.sv =====
// ----------------------------------------------------------------------------
// ssc_sqrt
// Integer square root by trial squaring, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ssc_pkg::ROOT_IN_W-1:0] value,
    output logic                         done,
    output logic [ssc_pkg::ROOT_W-1:0]    root
);

    import ssc_pkg::*;

    localparam int SQ_W = 2 * ROOT_W;

    logic [ROOT_IN_W-1:0] val_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [ROOT_W-1:0]    bit_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [ROOT_W-1:0]    trial;
    logic [SQ_W-1:0]      sq;
    logic                 fits;

    always_comb begin
        trial = root_reg | bit_reg;
        sq    = SQ_W'(trial) * SQ_W'(trial);
        fits  = sq <= SQ_W'(val_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= value;
            root_reg <= '0;
            bit_reg  <= {1'b1, {(ROOT_W-1){1'b0}}};
        end else if (busy_reg) begin
            if (fits) begin
                root_reg <= trial;
            end
            bit_reg <= {1'b0, bit_reg[ROOT_W-1:1]};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/ssc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer: accumulation, then a fixed program of multiply, divide and
// square-root steps, skipped on overflow, then loading of the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    input  ssc_pkg::ssc_sts_t sts,
    output ssc_pkg::ssc_cmd_t cmd
);

    import ssc_pkg::*;

    ssc_state_t state_reg, state_next;
    ssc_op_t    op_reg, op_next;
    logic       unit_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            op_reg    <= OP_FIRST;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (op_unit(op_reg))
            UNIT_DIV:  unit_done = sts.div_done;
            UNIT_SQRT: unit_done = sts.sqrt_done;
            default:   unit_done = sts.mul_done;
        endcase
        case (state_reg)
            ST_ACC: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                op_next    = OP_FIRST;
                state_next = sts.overflowed ? ST_OUT : ST_ISSUE;
            end
            ST_ISSUE: begin
                case (op_unit(op_reg))
                    UNIT_DIV:  cmd.start_div  = 1'b1;
                    UNIT_SQRT: cmd.start_sqrt = 1'b1;
                    default:   cmd.start_mul  = 1'b1;
                endcase
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (unit_done) begin
                    cmd.latch = 1'b1;
                    if (op_reg == OP_LAST) begin
                        state_next = ST_OUT;
                    end else begin
                        op_next    = ssc_op_t'(4'(op_reg + 4'd1));
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

endmodule

// ===== hdl/ssc_dp.sv =====
// ----------------------------------------------------------------------------
// ssc_dp
// Datapath: per-sample accumulators, shared multiplier, divider and root
// units, intermediate registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_dp #(
    parameter int MAX_COUNT = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ssc_pkg::ssc_cmd_t           cmd,
    output ssc_pkg::ssc_sts_t           sts,
    input  logic                        s_tvalid,
    input  logic [ssc_pkg::S_DATA_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ssc_pkg::M_DATA_W-1:0] m_tdata,
    output logic [ssc_pkg::M_USER_W-1:0] m_tuser
);

    import ssc_pkg::*;

    localparam int LOG   = $clog2(MAX_COUNT);
    localparam int CW    = $clog2(MAX_COUNT + 1);
    localparam int SW    = X_W + LOG;
    localparam int QW    = 2 * X_W - 1 + LOG;
    localparam int PW    = 2 * X_W + LOG;
    localparam int PRD_W = 2 * X_W;
    localparam int DW    = CW + QW;
    localparam int AW    = CW + PW;
    localparam int MW    = AW;
    localparam int TW    = 2 * MW + 1;
    localparam int NW    = 2 * AW + 2 * CORR_FRAC;
    localparam int VW    = 2 * DW;

    logic signed [X_W-1:0]   x_in, y_in;
    logic                    accept, take;

    logic [CW-1:0]           count_reg;
    logic                    ovf_reg;
    logic                    pv_reg;
    logic signed [PRD_W-1:0] pxx_reg, pyy_reg, pxy_reg;
    logic signed [SW-1:0]    acc_x_reg, acc_y_reg;
    logic [QW-1:0]           acc_xx_reg, acc_yy_reg;
    logic signed [PW-1:0]    acc_xy_reg;
    logic signed [X_W-1:0]   min_reg, max_reg;

    logic signed [TW-1:0]    tmp_reg;
    logic [DW-1:0]           dx_reg, dy_reg;
    logic signed [AW:0]      a_reg;
    logic [2*CW-1:0]         nn_reg;
    logic [VW-1:0]           dd_reg;
    logic [2*AW-1:0]         aa_reg;
    logic [X_W-1:0]          mean_reg;
    logic [VAR_W-1:0]        var_reg;
    logic [ROOT_IN_W-1:0]    qc_reg;
    logic [STD_W-1:0]        std_reg;
    logic [ROOT_W-1:0]       r_reg;

    logic [SW-1:0]           abs_x, abs_y;
    logic [PW-1:0]           abs_xy;
    logic [AW:0]             abs_a;
    logic                    sx_neg, sy_neg;

    logic [MW-1:0]           mul_a, mul_b;
    logic                    mul_neg;
    logic [2*MW-1:0]         mul_prod;
    logic                    mul_done;
    logic signed [TW-1:0]    sprod, diff;
    logic [NW-1:0]           div_num, div_quo;
    logic [VW-1:0]           div_den;
    logic                    div_done;
    logic [ROOT_IN_W-1:0]    root_in;
    logic [ROOT_W-1:0]       root_out;
    logic                    sqrt_done;

    logic                    m_tvalid_reg;
    logic [M_DATA_W-1:0]     out_data_reg, out_data_next;
    logic [M_USER_W-1:0]     out_user_reg, out_user_next;
    logic                    corr_valid;
    logic [CORR_W-1:0]       corr_mag, corr_val;

    assign x_in   = s_tdata[X_W-1:0];
    assign y_in   = s_tdata[2*X_W-1:X_W];
    assign accept = s_tvalid && cmd.in_ready;
    assign take   = accept && (count_reg < CW'(MAX_COUNT));

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            pv_reg     <= 1'b0;
            acc_x_reg  <= '0;
            acc_y_reg  <= '0;
            acc_xx_reg <= '0;
            acc_yy_reg <= '0;
            acc_xy_reg <= '0;
        end else begin
            pv_reg <= take;
            if (take) begin
                count_reg <= count_reg + CW'(1);
                acc_x_reg <= acc_x_reg + SW'(x_in);
                acc_y_reg <= acc_y_reg + SW'(y_in);
            end
            if (accept && !take) begin
                ovf_reg <= 1'b1;
            end
            if (pv_reg) begin
                acc_xx_reg <= acc_xx_reg + QW'(pxx_reg[PRD_W-2:0]);
                acc_yy_reg <= acc_yy_reg + QW'(pyy_reg[PRD_W-2:0]);
                acc_xy_reg <= acc_xy_reg + PW'(pxy_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pxx_reg <= PRD_W'(x_in) * PRD_W'(x_in);
            pyy_reg <= PRD_W'(y_in) * PRD_W'(y_in);
            pxy_reg <= PRD_W'(x_in) * PRD_W'(y_in);
            if (count_reg == '0) begin
                min_reg <= x_in;
                max_reg <= x_in;
            end else begin
                if (x_in < min_reg) begin
                    min_reg <= x_in;
                end
                if (x_in > max_reg) begin
                    max_reg <= x_in;
                end
            end
        end
    end

    always_comb begin
        sx_neg = acc_x_reg[SW-1];
        sy_neg = acc_y_reg[SW-1];
        abs_x  = sx_neg ? -acc_x_reg : acc_x_reg;
        abs_y  = sy_neg ? -acc_y_reg : acc_y_reg;
        abs_xy = acc_xy_reg[PW-1] ? -acc_xy_reg : acc_xy_reg;
        abs_a  = a_reg[AW] ? -a_reg : a_reg;
    end

    always_comb begin
        mul_a   = MW'(count_reg);
        mul_b   = MW'(count_reg);
        mul_neg = 1'b0;
        div_num = NW'(abs_x);
        div_den = VW'(count_reg);
        root_in = ROOT_IN_W'(var_reg);
        case (cmd.op)
            OP_N_SXX: begin
                mul_b = MW'(acc_xx_reg);
            end
            OP_SX_SX: begin
                mul_a = MW'(abs_x);
                mul_b = MW'(abs_x);
            end
            OP_N_SYY: begin
                mul_b = MW'(acc_yy_reg);
            end
            OP_SY_SY: begin
                mul_a = MW'(abs_y);
                mul_b = MW'(abs_y);
            end
            OP_N_SXY: begin
                mul_b   = MW'(abs_xy);
                mul_neg = acc_xy_reg[PW-1];
            end
            OP_SX_SY: begin
                mul_a   = MW'(abs_x);
                mul_b   = MW'(abs_y);
                mul_neg = sx_neg ^ sy_neg;
            end
            OP_DX_DY: begin
                mul_a = MW'(dx_reg);
                mul_b = MW'(dy_reg);
            end
            OP_A_A: begin
                mul_a = abs_a[AW-1:0];
                mul_b = abs_a[AW-1:0];
            end
            OP_DIV_VAR: begin
                div_num = NW'(dx_reg);
                div_den = VW'(nn_reg);
            end
            OP_DIV_CORR: begin
                div_num = {aa_reg, {(2*CORR_FRAC){1'b0}}};
                div_den = dd_reg;
            end
            OP_SQRT_CORR: begin
                root_in = qc_reg;
            end
            default: begin
            end
        endcase
    end

    ssc_mul #(.W(MW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_mul),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ssc_div #(.NW(NW), .DVW(VW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_div),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    ssc_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_sqrt),
        .value   (root_in),
        .done    (sqrt_done),
        .root    (root_out)
    );

    always_comb begin
        sprod = mul_neg ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
        diff  = tmp_reg - sprod;
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            case (cmd.op)
                OP_N_SXX, OP_N_SYY, OP_N_SXY: tmp_reg <= sprod;
                OP_SX_SX:     dx_reg   <= diff[DW-1:0];
                OP_SY_SY:     dy_reg   <= diff[DW-1:0];
                OP_SX_SY:     a_reg    <= diff[AW:0];
                OP_N_N:       nn_reg   <= mul_prod[2*CW-1:0];
                OP_DX_DY:     dd_reg   <= mul_prod[VW-1:0];
                OP_A_A:       aa_reg   <= mul_prod;
                OP_DIV_MEAN:  mean_reg <= sx_neg ? -div_quo[X_W-1:0] : div_quo[X_W-1:0];
                OP_DIV_VAR:   var_reg  <= div_quo[VAR_W-1:0];
                OP_DIV_CORR:  qc_reg   <= div_quo[ROOT_IN_W-1:0];
                OP_SQRT_VAR:  std_reg  <= root_out[STD_W-1:0];
                OP_SQRT_CORR: r_reg    <= root_out;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        corr_valid    = (count_reg >= CW'(2)) && (dx_reg != '0) && (dy_reg != '0);
        corr_mag      = CORR_W'(r_reg);
        corr_val      = a_reg[AW] ? -corr_mag : corr_mag;
        out_data_next = '0;
        out_user_next = '0;
        if (ovf_reg) begin
            out_user_next[USER_STATUS] = 1'b1;
        end else begin
            out_data_next[OFF_COUNT +: COUNT_OUT_W] = COUNT_OUT_W'(count_reg);
            out_data_next[OFF_SUM +: SUM_OUT_W]     = SUM_OUT_W'(acc_x_reg);
            out_data_next[OFF_MEAN +: X_W]          = mean_reg;
            out_data_next[OFF_MIN +: X_W]           = min_reg;
            out_data_next[OFF_MAX +: X_W]           = max_reg;
            out_data_next[OFF_VAR +: VAR_W]         = var_reg;
            out_data_next[OFF_STD +: STD_W]         = std_reg;
            if (corr_valid) begin
                out_data_next[OFF_CORR +: CORR_W]  = corr_val;
                out_user_next[USER_CORR_VALID]     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    always_comb begin
        sts.overflowed = ovf_reg;
        sts.mul_done   = mul_done;
        sts.div_done   = div_done;
        sts.sqrt_done  = sqrt_done;
        sts.out_busy   = m_tvalid_reg && !m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== hdl/sample_statistics_correlation.sv =====
// ----------------------------------------------------------------------------
// sample_statistics_correlation
// Paired Q12.12 samples are accepted one per clock cycle while the block
// accumulates; the sample marked by tlast closes the set and starts a fixed
// sequence on one shared shift-and-add multiplier (nine products of MW-bit
// operands, MW = clog2(MAX_COUNT+1)+clog2(MAX_COUNT)+48, 69 at the default),
// one restoring divider (three quotients of NW bits, NW = 2*MW+60, 198 at
// the default) and one root unit (two roots). A set with too many samples
// skips that sequence and goes straight to the result register. No sample
// is taken during that sequence, while a finished result waits in its own
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_statistics_correlation #(
    parameter int MAX_COUNT = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // x_value [23:0], y_value [47:24]
    input  logic [ssc_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // sample_count [10:0], sum_x [44:11], mean_x [68:45], min_x [92:69],
    // max_x [116:93], variance_x [163:117], stddev_x [187:164],
    // correlation [219:188], zero [223:220]
    output logic [ssc_pkg::M_DATA_W-1:0] m_tdata,
    // status [0], correlation_valid [1]
    output logic [ssc_pkg::M_USER_W-1:0] m_tuser
);

    import ssc_pkg::*;

    ssc_cmd_t cmd;
    ssc_sts_t sts;

    ssc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssc_dp #(.MAX_COUNT(MAX_COUNT)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign s_tready = cmd.in_ready;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(m_tvalid && !m_tready))
        else $error("result register loaded while a result is still pending");

    a_stop_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("request taken right after the closing sample");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[USER_STATUS]) |-> (m_tdata == '0))
        else $error("error result carries nonzero fields");

    a_corr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[USER_CORR_VALID]) |-> (m_tdata[OFF_CORR +: CORR_W] == '0))
        else $error("invalid correlation is not zero");

endmodule
